// File: rtl/a32x_pkg.sv
// shared types, decode constants and register indexes for the a32 execute unit
package a32x_pkg;

   localparam int unsigned XLEN      = 32;
   localparam int unsigned NUM_REGS  = 16;
   localparam int unsigned REG_AW    = 4;
   localparam int unsigned CSR_AW    = 3;
   localparam int unsigned REQ_DW    = 64;
   localparam int unsigned RSP_DW    = 136;
   localparam int unsigned RSP_UW    = 2;

   // architectural register numbers
   localparam logic [REG_AW-1:0] REG_R0 = 4'd0;
   localparam logic [REG_AW-1:0] REG_R1 = 4'd1;
   localparam logic [REG_AW-1:0] REG_R2 = 4'd2;
   localparam logic [REG_AW-1:0] REG_R3 = 4'd3;
   localparam logic [REG_AW-1:0] REG_SP = 4'd13;
   localparam logic [REG_AW-1:0] REG_LR = 4'd14;
   localparam logic [REG_AW-1:0] REG_PC = 4'd15;

   // configuration register indexes
   localparam logic [CSR_AW-1:0] CSR_START_PC  = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_STACK_TOP = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_ARG_ZERO  = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_ARG_ONE   = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_ARG_TWO   = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_ARG_THREE = 3'd5;

   // instruction field codes
   localparam logic [23:0] BX_PATTERN  = 24'h12FFF1;
   localparam logic [3:0]  OPC_ADD     = 4'b0100;
   localparam logic [3:0]  OPC_SUB     = 4'b0010;
   localparam logic [3:0]  OPC_MOV     = 4'b1101;
   localparam logic [3:0]  OPC_CMP     = 4'b1010;
   localparam logic [2:0]  BRANCH_CODE = 3'b101;
   localparam logic [3:0]  COND_EQ     = 4'b0000;
   localparam logic [3:0]  COND_LT     = 4'b1011;
   localparam logic [3:0]  COND_GT     = 4'b1100;
   localparam logic [3:0]  COND_LE     = 4'b1101;
   localparam logic [1:0]  OP_DATA     = 2'b00;
   localparam logic [1:0]  OP_MEM      = 2'b01;

   // request kinds
   localparam logic REQ_INSTR = 1'b0;
   localparam logic REQ_LOAD  = 1'b1;

   // memory operation codes
   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_LDW   = 2'd1;
   localparam logic [1:0] MEM_LDB   = 2'd2;
   localparam logic [1:0] MEM_STW   = 2'd3;

   typedef logic [XLEN-1:0] word_type;
   typedef word_type [NUM_REGS-1:0] reg_array_type;

   // architectural state seen by the execute logic
   typedef struct packed {
      logic              flag_n;
      logic              flag_z;
      logic              load_pending;
      logic [REG_AW-1:0] load_dest;
      logic              load_is_byte;
   } ctrl_state_type;

   // state update produced for one transaction
   typedef struct packed {
      logic              wr_en;
      logic [REG_AW-1:0] wr_addr;
      word_type          wr_data;
      logic              pc_en;
      word_type          pc_data;
      logic              lr_en;
      word_type          lr_data;
      logic              flags_en;
      logic              flag_n;
      logic              flag_z;
      logic              load_set;
      logic              load_clr;
      logic [REG_AW-1:0] load_dest;
      logic              load_is_byte;
   } update_type;

   // one result transaction
   typedef struct packed {
      word_type   next_pc;
      logic [1:0] mem_op;
      word_type   mem_addr;
      word_type   store_value;
      logic       halted;
      word_type   return_value;
      logic       bad_instr;
   } rsp_item_type;

endpackage

// File: rtl/a32x_state.sv
// register file, flags and pending load tracking for the a32 execute unit
module a32x_state
   import a32x_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CSR_AW-1:0]   csr_index,
   input  word_type            csr_wdata,
   input  logic                step_en,
   input  update_type          upd,
   output reg_array_type       regs,
   output ctrl_state_type      ctrl
);

   reg_array_type  regs_ff;
   ctrl_state_type ctrl_ff;

   assign regs = regs_ff;
   assign ctrl = ctrl_ff;

   // register file writes: configuration first, otherwise instruction results
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_PC:  regs_ff[REG_PC] <= csr_wdata;
            CSR_STACK_TOP: regs_ff[REG_SP] <= csr_wdata;
            CSR_ARG_ZERO:  regs_ff[REG_R0] <= csr_wdata;
            CSR_ARG_ONE:   regs_ff[REG_R1] <= csr_wdata;
            CSR_ARG_TWO:   regs_ff[REG_R2] <= csr_wdata;
            CSR_ARG_THREE: regs_ff[REG_R3] <= csr_wdata;
            default: ;
         endcase
      end else if (step_en) begin
         if (upd.wr_en) begin
            regs_ff[upd.wr_addr] <= upd.wr_data;
         end
         if (upd.lr_en) begin
            regs_ff[REG_LR] <= upd.lr_data;
         end
         if (upd.pc_en) begin
            regs_ff[REG_PC] <= upd.pc_data;
         end
      end
   end

   // flags and load tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (step_en) begin
         if (upd.flags_en) begin
            ctrl_ff.flag_n <= upd.flag_n;
            ctrl_ff.flag_z <= upd.flag_z;
         end
         if (upd.load_set) begin
            ctrl_ff.load_pending <= 1'b1;
            ctrl_ff.load_dest    <= upd.load_dest;
            ctrl_ff.load_is_byte <= upd.load_is_byte;
         end else if (upd.load_clr) begin
            ctrl_ff.load_pending <= 1'b0;
         end
      end
   end

endmodule

// File: rtl/a32x_exec.sv
// decode and execute of one instruction or load return, purely combinational
module a32x_exec
   import a32x_pkg::*;
(
   input  logic            req_kind,
   input  word_type        instr_word,
   input  word_type        load_data,
   input  reg_array_type   regs,
   input  ctrl_state_type  ctrl,
   output update_type      upd,
   output rsp_item_type    item
);

   word_type          pc;
   word_type          pc_plus4;
   word_type          opnd;
   word_type          rn_val;
   word_type          rm_val;
   word_type          diff;
   word_type          br_off;
   word_type          new_pc;
   word_type          new_r0;
   logic [REG_AW-1:0] rd;
   logic [REG_AW-1:0] rn;
   logic [REG_AW-1:0] rm;
   logic [1:0]        op;
   logic [3:0]        opc;
   logic [3:0]        cond;
   logic              mov_go;
   logic              br_taken;
   logic              is_byte;

   // instruction fields and operands
   always_comb begin
      pc       = regs[REG_PC];
      pc_plus4 = pc + word_type'(4);
      rd       = instr_word[15:12];
      rn       = instr_word[19:16];
      rm       = instr_word[3:0];
      op       = instr_word[27:26];
      opc      = instr_word[24:21];
      cond     = instr_word[31:28];
      rn_val   = regs[rn];
      rm_val   = regs[rm];
      opnd     = instr_word[25] ? {24'd0, instr_word[7:0]} : rm_val;
      diff     = rn_val - opnd;
      br_off   = {{6{instr_word[23]}}, instr_word[23:0], 2'b00};
      is_byte  = instr_word[22];
   end

   // condition evaluation for conditional move and branch
   always_comb begin
      case (cond)
         COND_LE: mov_go = ctrl.flag_z | ctrl.flag_n;
         COND_GT: mov_go = ~ctrl.flag_n & ~ctrl.flag_z;
         default: mov_go = 1'b1;
      endcase
      case (cond)
         COND_EQ: br_taken = ctrl.flag_z;
         COND_LT: br_taken = ctrl.flag_n;
         default: br_taken = 1'b1;
      endcase
   end

   // state update and memory request
   always_comb begin
      upd              = '0;
      item             = '0;
      item.mem_op      = MEM_NONE;
      if (req_kind == REQ_LOAD) begin
         if (ctrl.load_pending) begin
            upd.wr_en    = 1'b1;
            upd.wr_addr  = ctrl.load_dest;
            upd.wr_data  = ctrl.load_is_byte ? {24'd0, load_data[7:0]} : load_data;
            upd.load_clr = 1'b1;
         end
      end else if (!ctrl.load_pending) begin
         if (instr_word[27:4] == BX_PATTERN) begin
            upd.pc_en   = 1'b1;
            upd.pc_data = rm_val;
         end else if (op == OP_DATA && opc == OPC_ADD) begin
            upd.wr_en   = 1'b1;
            upd.wr_addr = rd;
            upd.wr_data = rn_val + opnd;
            upd.pc_en   = (rd != REG_PC);
            upd.pc_data = pc_plus4;
         end else if (op == OP_DATA && opc == OPC_SUB) begin
            upd.wr_en   = 1'b1;
            upd.wr_addr = rd;
            upd.wr_data = diff;
            upd.pc_en   = (rd != REG_PC);
            upd.pc_data = pc_plus4;
         end else if (op == OP_DATA && opc == OPC_MOV) begin
            upd.wr_en   = mov_go;
            upd.wr_addr = rd;
            upd.wr_data = opnd;
            upd.pc_en   = !mov_go || (rd != REG_PC);
            upd.pc_data = pc_plus4;
         end else if (op == OP_MEM && !instr_word[20]) begin
            item.mem_op      = MEM_STW;
            item.mem_addr    = rn_val;
            item.store_value = regs[rd];
            upd.pc_en        = (rd != REG_PC);
            upd.pc_data      = pc_plus4;
         end else if (op == OP_MEM) begin
            item.mem_op       = is_byte ? MEM_LDB : MEM_LDW;
            item.mem_addr     = is_byte ? rn_val + {24'd0, instr_word[7:0]} : rn_val;
            upd.load_set      = 1'b1;
            upd.load_dest     = rd;
            upd.load_is_byte  = is_byte;
            upd.pc_en         = (rd != REG_PC);
            upd.pc_data       = pc_plus4;
         end else if (op == OP_DATA && opc == OPC_CMP) begin
            upd.flags_en = 1'b1;
            upd.flag_z   = (diff == '0);
            upd.flag_n   = diff[XLEN-1];
            upd.pc_en    = 1'b1;
            upd.pc_data  = pc_plus4;
         end else if (instr_word[27:25] == BRANCH_CODE) begin
            upd.pc_en   = 1'b1;
            upd.pc_data = br_taken ? pc + word_type'(8) + br_off : pc_plus4;
            upd.lr_en   = br_taken & instr_word[24];
            upd.lr_data = pc_plus4;
         end else begin
            item.bad_instr = 1'b1;
         end
      end

      // values after this transaction for the result
      if (upd.pc_en) begin
         new_pc = upd.pc_data;
      end else if (upd.wr_en && upd.wr_addr == REG_PC) begin
         new_pc = upd.wr_data;
      end else begin
         new_pc = pc;
      end
      if (upd.wr_en && upd.wr_addr == REG_R0) begin
         new_r0 = upd.wr_data;
      end else begin
         new_r0 = regs[REG_R0];
      end
      item.next_pc      = new_pc;
      item.halted       = (new_pc == '0);
      item.return_value = (new_pc == '0) ? new_r0 : '0;
   end

endmodule

// File: rtl/a32x_out_queue.sv
// result register with a skid entry that takes one more input during a stall
module a32x_out_queue
   import a32x_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  rsp_item_type  push_item,
   output logic          can_push,
   output logic          out_valid,
   input  logic          out_ready,
   output rsp_item_type  out_item
);

   logic         main_valid_ff;
   logic         skid_valid_ff;
   rsp_item_type main_ff;
   rsp_item_type skid_ff;
   logic         pop;

   assign pop       = main_valid_ff & out_ready;
   assign can_push  = ~skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_item  = main_ff;

   // occupancy control
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   // payload movement
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            main_ff <= skid_ff;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_ff <= push_item;
         end else begin
            main_ff <= push_item;
         end
      end
   end

endmodule

// File: rtl/a32_subset_execute_unit.sv
// top level of the a32 subset execute unit
//
//  channel  | direction | content
//  ---------+-----------+-------------------------------------------------------
//  req_*    | in        | instruction word or load return, one per transaction
//  rsp_*    | out       | next pc, memory request, halt and error status
//  csr_*    | in        | start pc, stack top and argument register writes
//
// one transaction per cycle while rsp does not stall; each result is registered
// in the result register, or in the skid entry if rsp stalls.
// a result register plus a skid entry let one more request in while rsp stalls.
// synchronous active-high reset clears all registers, flags and load tracking.
module a32_subset_execute_unit
   import a32x_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_DW-1:0]   req_tdata,   // instr_word, load_data
   input  logic                req_tuser,   // req_type
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_DW-1:0]   rsp_tdata,   // next_pc, mem_addr, store_value,
                                            // halted, return_value, bad_instr, zero pad
   output logic [RSP_UW-1:0]   rsp_tuser,   // mem_op
   input  logic                csr_we,
   input  logic [CSR_AW-1:0]   csr_index,
   input  word_type            csr_wdata
);

   reg_array_type  regs;
   ctrl_state_type ctrl;
   update_type     upd;
   rsp_item_type   item;
   rsp_item_type   out_item;
   logic           can_push;
   logic           step_en;

   assign req_tready = can_push;
   assign step_en    = req_tvalid & can_push;

   // architectural state
   a32x_state u_state (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step_en   (step_en),
      .upd       (upd),
      .regs      (regs),
      .ctrl      (ctrl)
   );

   // execute
   a32x_exec u_exec (
      .req_kind   (req_tuser),
      .instr_word (req_tdata[31:0]),
      .load_data  (req_tdata[63:32]),
      .regs       (regs),
      .ctrl       (ctrl),
      .upd        (upd),
      .item       (item)
   );

   // result staging
   a32x_out_queue u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (step_en),
      .push_item (item),
      .can_push  (can_push),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   // pack result fields
   assign rsp_tuser = out_item.mem_op;
   assign rsp_tdata = {6'd0,
                       out_item.bad_instr,
                       out_item.return_value,
                       out_item.halted,
                       out_item.store_value,
                       out_item.mem_addr,
                       out_item.next_pc};

endmodule
